// ===== design/wdac_pkg.sv =====
package wdac_pkg;

   // Default history length.
   localparam int HISTORY_DEPTH = 20;

   // Field widths.
   localparam int DEPTH_W  = 14;
   localparam int X_W      = 10;
   localparam int GAIN_W   = 7;
   localparam int SEARCH_W = 12;
   localparam int SPEED_W  = 10;
   localparam int TURN_W   = 18;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 14;

   // Limits.
   localparam int DEPTH_MIN   = 100;
   localparam int DEPTH_MAX   = 10000;
   localparam int TURN_LIMIT  = 102300;
   localparam int SPEED_LIMIT = 1000;

   // Register reset values.
   localparam logic [X_W-1:0]      IMAGE_CENTER_RST    = 10'd320;
   localparam logic [GAIN_W-1:0]   STEER_GAIN_RST      = 7'd10;
   localparam logic [SEARCH_W-1:0] SEARCH_RATE_RST     = 12'd500;
   localparam logic [DEPTH_W-1:0]  STOP_DISTANCE_RST   = 14'd200;
   localparam logic [DEPTH_W-1:0]  ARRIVE_DISTANCE_RST = 14'd400;
   localparam logic [SPEED_W-1:0]  MIN_SPEED_RST       = 10'd50;
   localparam logic [SPEED_W-1:0]  MAX_SPEED_RST       = 10'd300;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_CENTER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_RATE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DISTANCE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_DISTANCE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED       = 3'd6;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_DEPTH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

// ===== design/wdac_history_mem.sv =====
module wdac_history_mem #(
   parameter int DEPTH = wdac_pkg::HISTORY_DEPTH,
   parameter int WIDTH = wdac_pkg::DEPTH_W,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/wdac_divider.sv =====
module wdac_divider #(
   parameter int DW = 22,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [VW:0] shifted;
   logic [VW:0] diff;
   logic        ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      ge      = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? diff[VW-1:0] : shifted[VW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/weighted_depth_approach_controller.sv =====
// Sequence: a depth beat passes through READ, UPDATE, DIV_START and DIV_WAIT to FINISH;
// a tick, start or unused beat goes straight from IDLE to FINISH. FINISH waits while the held result is stalled.
// Only one beat is in flight: the next beat is taken once the block is back in IDLE, after
// the serial divider (one quotient bit per cycle) and the history read for a depth beat.
// Reset is synchronous and active high: registers return to their defaults, history count,
// sums, average and tracking clear, and the block is ready in the first cycle after reset.
module weighted_depth_approach_controller #(
   parameter int HISTORY_DEPTH = wdac_pkg::HISTORY_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wdac_pkg::KIND_W-1:0]         req_kind,
   input  logic [wdac_pkg::DEPTH_W-1:0]        req_depth_mm,
   input  logic                                req_target_seen,
   input  logic [wdac_pkg::X_W-1:0]            req_target_x,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wdac_pkg::DEPTH_W-1:0]        rsp_weighted_average,
   output logic [wdac_pkg::SPEED_W-1:0]        rsp_forward_speed,
   output logic signed [wdac_pkg::TURN_W-1:0]  rsp_turn_rate,
   output logic                                rsp_arrived,
   output logic                                rsp_tracking_on,
   // Configuration write port.
   input  logic                                csr_write_en,
   input  logic [wdac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wdac_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   localparam int DEPTH_W = wdac_pkg::DEPTH_W;
   localparam int SPEED_W = wdac_pkg::SPEED_W;
   localparam int TURN_W  = wdac_pkg::TURN_W;
   localparam int X_W     = wdac_pkg::X_W;
   localparam int GAIN_W  = wdac_pkg::GAIN_W;

   // Widths that follow from the history length.
   localparam int SW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW     = $clog2(HISTORY_DEPTH + 1);
   localparam int TW_MAX = HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2;
   localparam int TWW    = $clog2(TW_MAX + 1);
   localparam int PSW    = $clog2(HISTORY_DEPTH * wdac_pkg::DEPTH_MAX + 1);
   localparam int WSW    = $clog2(TW_MAX * wdac_pkg::DEPTH_MAX + 1);
   localparam int PW     = 2 * CW + 2;
   localparam int PROD_W = GAIN_W + X_W + 2;

   localparam logic [CW-1:0]      FullCount = CW'(HISTORY_DEPTH);
   localparam logic [CW:0]        DepthWide = (CW + 1)'(HISTORY_DEPTH);
   localparam logic [SW-1:0]      LastSlot  = SW'(HISTORY_DEPTH - 1);
   localparam logic [WSW-1:0]     DepthMul  = WSW'(HISTORY_DEPTH);
   localparam logic [DEPTH_W-1:0] DepthMin  = DEPTH_W'(wdac_pkg::DEPTH_MIN);
   localparam logic [DEPTH_W-1:0] DepthMax  = DEPTH_W'(wdac_pkg::DEPTH_MAX);
   localparam logic [WSW-1:0]     AvgMax    = WSW'(wdac_pkg::DEPTH_MAX);
   localparam logic signed [PROD_W-1:0] TurnHi = PROD_W'(wdac_pkg::TURN_LIMIT);
   localparam logic signed [PROD_W-1:0] TurnLo = -TurnHi;
   localparam logic [DEPTH_W-2:0] SpeedLim  = (DEPTH_W - 1)'(wdac_pkg::SPEED_LIMIT);

   // Configuration registers.
   logic [X_W-1:0]                    image_center_ff;
   logic [GAIN_W-1:0]                 steer_gain_ff;
   logic [wdac_pkg::SEARCH_W-1:0]     search_rate_ff;
   logic [DEPTH_W-1:0]                stop_distance_ff;
   logic [DEPTH_W-1:0]                arrive_distance_ff;
   logic [SPEED_W-1:0]                min_speed_ff;
   logic [SPEED_W-1:0]                max_speed_ff;

   // Control and history bookkeeping.
   wdac_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SW-1:0]      oldest_ff, oldest_in;
   logic [PSW-1:0]     psum_ff, psum_in;
   logic [WSW-1:0]     wsum_ff, wsum_in;
   logic               tracking_ff, tracking_in;
   logic [DEPTH_W-1:0] avg_ff, avg_in;

   // Captured request beat.
   logic [wdac_pkg::KIND_W-1:0] kind_ff;
   logic [DEPTH_W-1:0]          depth_ff;
   logic                        seen_ff;
   logic [X_W-1:0]              tx_ff;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_W-1:0]         rsp_avg_ff;
   logic [SPEED_W-1:0]         rsp_speed_ff;
   logic signed [TURN_W-1:0]   rsp_turn_ff;
   logic                       rsp_arrived_ff;
   logic                       rsp_tracking_ff;

   logic req_accept;
   logic out_free;
   logic mem_rd_en;
   logic mem_wr_en;
   logic div_start;
   logic upd_en;
   logic fin_fire;
   logic div_done;
   logic [WSW-1:0] div_quotient;
   logic [DEPTH_W-1:0] old_depth;
   logic [DEPTH_W-1:0] depth_clamped;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != wdac_pkg::ST_IDLE);
   // The result register frees when it is empty or being taken in this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Depth is clamped into range as it is captured.
   always_comb begin
      depth_clamped = req_depth_mm;
      if (req_depth_mm < DepthMin) begin
         depth_clamped = DepthMin;
      end else if (req_depth_mm > DepthMax) begin
         depth_clamped = DepthMax;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wdac_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_kind == wdac_pkg::KIND_DEPTH) ? wdac_pkg::ST_READ
                                                             : wdac_pkg::ST_FINISH;
            end
         end
         wdac_pkg::ST_READ:      state_in = wdac_pkg::ST_UPDATE;
         wdac_pkg::ST_UPDATE:    state_in = wdac_pkg::ST_DIV_START;
         wdac_pkg::ST_DIV_START: state_in = wdac_pkg::ST_DIV_WAIT;
         wdac_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = wdac_pkg::ST_FINISH;
            end
         end
         wdac_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = wdac_pkg::ST_IDLE;
            end
         end
         default: state_in = wdac_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs.
   always_comb begin
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      div_start = 1'b0;
      upd_en    = 1'b0;
      fin_fire  = 1'b0;
      unique case (state_ff)
         wdac_pkg::ST_READ:      mem_rd_en = 1'b1;
         wdac_pkg::ST_UPDATE: begin
            mem_wr_en = 1'b1;
            upd_en    = 1'b1;
         end
         wdac_pkg::ST_DIV_START: div_start = 1'b1;
         wdac_pkg::ST_FINISH:    fin_fire  = out_free;
         default: begin
         end
      endcase
   end

   // History update. When the history is full the oldest entry, read from memory in the
   // previous cycle, is replaced and every remaining weight drops by one.
   logic          full;
   logic [CW:0]   slot_sum;
   logic [SW-1:0] wr_slot;
   logic [CW-1:0] count_next;

   always_comb begin
      full       = (count_ff == FullCount);
      count_next = count_ff + CW'(1);
      slot_sum   = (CW + 1)'(oldest_ff) + (CW + 1)'(count_ff);
      if (slot_sum >= DepthWide) begin
         slot_sum = slot_sum - DepthWide;
      end
      wr_slot   = full ? oldest_ff : SW'(slot_sum);
      count_in  = count_ff;
      oldest_in = oldest_ff;
      psum_in   = psum_ff;
      wsum_in   = wsum_ff;
      if (upd_en) begin
         if (!full) begin
            count_in = count_next;
            psum_in  = psum_ff + PSW'(depth_ff);
            wsum_in  = wsum_ff + WSW'(WSW'(count_next) * WSW'(depth_ff));
         end else begin
            wsum_in   = wsum_ff - WSW'(psum_ff) + WSW'(DepthMul * WSW'(depth_ff));
            psum_in   = psum_ff - PSW'(old_depth) + PSW'(depth_ff);
            oldest_in = (oldest_ff == LastSlot) ? '0 : oldest_ff + SW'(1);
         end
      end
   end

   // Sum of weights n(n+1)/2 for the divider.
   logic [PW-1:0]  weight_prod;
   logic [TWW-1:0] weight_div;

   assign weight_prod = PW'(count_ff) * (PW'(count_ff) + PW'(1));
   assign weight_div  = TWW'(weight_prod >> 1);

   always_comb begin
      avg_in = avg_ff;
      if (div_done) begin
         avg_in = (div_quotient > AvgMax) ? DepthMax : DEPTH_W'(div_quotient);
      end
   end

   // Result of the current beat.
   logic signed [X_W:0]       err;
   logic signed [PROD_W-1:0]  turn_prod;
   logic signed [PROD_W-1:0]  turn_sat;
   logic [DEPTH_W-2:0]        speed_calc;
   logic [SPEED_W-1:0]        res_speed;
   logic signed [TURN_W-1:0]  res_turn;
   logic                      res_arrived;
   logic                      res_tracking;

   assign err       = $signed({1'b0, image_center_ff}) - $signed({1'b0, tx_ff});
   assign turn_prod = PROD_W'($signed({1'b0, steer_gain_ff})) * PROD_W'(err);

   always_comb begin
      turn_sat = turn_prod;
      if (turn_prod > TurnHi) begin
         turn_sat = TurnHi;
      end else if (turn_prod < TurnLo) begin
         turn_sat = TurnLo;
      end
      speed_calc = avg_ff[DEPTH_W-1:1];
      if (speed_calc < (DEPTH_W - 1)'(min_speed_ff)) begin
         speed_calc = (DEPTH_W - 1)'(min_speed_ff);
      end
      if (speed_calc > (DEPTH_W - 1)'(max_speed_ff)) begin
         speed_calc = (DEPTH_W - 1)'(max_speed_ff);
      end
      if (speed_calc > SpeedLim) begin
         speed_calc = SpeedLim;
      end

      res_speed    = '0;
      res_turn     = '0;
      res_arrived  = 1'b0;
      res_tracking = tracking_ff;
      case (kind_ff)
         wdac_pkg::KIND_DEPTH: begin
            // Arrival only ends an active approach.
            if (tracking_ff && (avg_ff < arrive_distance_ff)) begin
               res_arrived  = 1'b1;
               res_tracking = 1'b0;
            end
         end
         wdac_pkg::KIND_START: res_tracking = 1'b1;
         wdac_pkg::KIND_TICK: begin
            if (tracking_ff) begin
               if (!seen_ff) begin
                  res_turn = $signed(TURN_W'(search_rate_ff));
               end else begin
                  res_turn = TURN_W'(turn_sat);
                  if (avg_ff > stop_distance_ff) begin
                     res_speed = SPEED_W'(speed_calc);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign tracking_in  = fin_fire ? res_tracking : tracking_ff;
   assign rsp_valid_in = fin_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= wdac_pkg::ST_IDLE;
         count_ff           <= '0;
         oldest_ff          <= '0;
         psum_ff            <= '0;
         wsum_ff            <= '0;
         tracking_ff        <= 1'b0;
         avg_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         image_center_ff    <= wdac_pkg::IMAGE_CENTER_RST;
         steer_gain_ff      <= wdac_pkg::STEER_GAIN_RST;
         search_rate_ff     <= wdac_pkg::SEARCH_RATE_RST;
         stop_distance_ff   <= wdac_pkg::STOP_DISTANCE_RST;
         arrive_distance_ff <= wdac_pkg::ARRIVE_DISTANCE_RST;
         min_speed_ff       <= wdac_pkg::MIN_SPEED_RST;
         max_speed_ff       <= wdac_pkg::MAX_SPEED_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         psum_ff      <= psum_in;
         wsum_ff      <= wsum_in;
         tracking_ff  <= tracking_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               wdac_pkg::CSR_IMAGE_CENTER:    image_center_ff    <= X_W'(csr_wdata);
               wdac_pkg::CSR_STEER_GAIN:      steer_gain_ff      <= GAIN_W'(csr_wdata);
               wdac_pkg::CSR_SEARCH_RATE:     search_rate_ff     <=
                                                 wdac_pkg::SEARCH_W'(csr_wdata);
               wdac_pkg::CSR_STOP_DISTANCE:   stop_distance_ff   <= csr_wdata;
               wdac_pkg::CSR_ARRIVE_DISTANCE: arrive_distance_ff <= csr_wdata;
               wdac_pkg::CSR_MIN_SPEED:       min_speed_ff       <= SPEED_W'(csr_wdata);
               wdac_pkg::CSR_MAX_SPEED:       max_speed_ff       <= SPEED_W'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
      if (req_accept) begin
         kind_ff  <= req_kind;
         depth_ff <= depth_clamped;
         seen_ff  <= req_target_seen;
         tx_ff    <= req_target_x;
      end
      if (fin_fire) begin
         rsp_avg_ff      <= avg_ff;
         rsp_speed_ff    <= res_speed;
         rsp_turn_ff     <= res_turn;
         rsp_arrived_ff  <= res_arrived;
         rsp_tracking_ff <= res_tracking;
      end
   end

   // The history samples themselves live in a one-port-read, one-port-write memory.
   wdac_history_mem #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (DEPTH_W),
      .AW    (SW)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_slot),
      .wr_data (depth_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (old_depth)
   );

   // Weighted sum divided by the sum of weights, one bit per cycle.
   wdac_divider #(
      .DW (WSW),
      .VW (TWW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wsum_ff),
      .divisor  (weight_div),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_weighted_average = rsp_avg_ff;
   assign rsp_forward_speed    = rsp_speed_ff;
   assign rsp_turn_rate        = rsp_turn_ff;
   assign rsp_arrived          = rsp_arrived_ff;
   assign rsp_tracking_on      = rsp_tracking_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("history count exceeds depth");

   a_oldest_only_full: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff != '0) |-> full)
      else $error("oldest slot moved before history filled");

   a_arrived_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_arrived) |-> !rsp_tracking_on)
      else $error("arrival reported with tracking still on");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != wdac_pkg::ST_IDLE))
      else $error("accepted beat did not start processing");

   a_avg_bound: assert property (@(posedge clock) disable iff (reset)
      avg_ff <= DepthMax)
      else $error("weighted average above depth limit");
`endif

endmodule

// ===== tb/sv/tb_weighted_depth_approach_controller.sv =====
module tb_weighted_depth_approach_controller;

   localparam int KIND_W        = wdac_pkg::KIND_W;
   localparam int DEPTH_W       = wdac_pkg::DEPTH_W;
   localparam int SPEED_W       = wdac_pkg::SPEED_W;
   localparam int TURN_W        = wdac_pkg::TURN_W;
   localparam int X_W           = wdac_pkg::X_W;
   localparam int GAIN_W        = wdac_pkg::GAIN_W;
   localparam int SEARCH_W      = wdac_pkg::SEARCH_W;
   localparam int CSR_IDX_W     = wdac_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W     = wdac_pkg::CSR_DAT_W;
   localparam int HISTORY_DEPTH = wdac_pkg::HISTORY_DEPTH;
   localparam int DEPTH_MIN     = wdac_pkg::DEPTH_MIN;
   localparam int DEPTH_MAX     = wdac_pkg::DEPTH_MAX;
   localparam int TURN_LIMIT    = wdac_pkg::TURN_LIMIT;
   localparam int SPEED_LIMIT   = wdac_pkg::SPEED_LIMIT;

   // The package defines no name for the fourth kind code. The block must
   // ignore that code.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // A depth beat holds the block through the history read, the update and the serial division.
   // This margin is used before register writes and at the end of the run.
   localparam int SETTLE_CYCLES = HISTORY_DEPTH + 12;

   // Percentage of cycles in which a side idles or stalls while idling is on.
   localparam int IDLE_PERCENT = 17;

   typedef struct {
      logic [DEPTH_W-1:0]       average;
      logic [SPEED_W-1:0]       speed;
      logic signed [TURN_W-1:0] turn;
      logic                     arrived;
      logic                     tracking;
   } approach_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid;
   logic                      req_stall;
   logic [KIND_W-1:0]         req_kind;
   logic [DEPTH_W-1:0]        req_depth_mm;
   logic                      req_target_seen;
   logic [X_W-1:0]            req_target_x;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [DEPTH_W-1:0]        rsp_weighted_average;
   logic [SPEED_W-1:0]        rsp_forward_speed;
   logic signed [TURN_W-1:0]  rsp_turn_rate;
   logic                      rsp_arrived;
   logic                      rsp_tracking_on;

   logic                      csr_write_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DAT_W-1:0]      csr_wdata;

   // These flags switch the random idle cycles on the request side and the
   // random stalls on the reply side.
   logic sender_idles = 1'b1;
   logic receiver_stalls = 1'b1;

   approach_reply_type pending_replies[$];
   int mismatch_count = 0;
   int beats_sent = 0;

   // Predictor copy of the control registers.
   logic [X_W-1:0]      cfg_center;
   logic [GAIN_W-1:0]   cfg_gain;
   logic [SEARCH_W-1:0] cfg_search;
   logic [DEPTH_W-1:0]  cfg_stop;
   logic [DEPTH_W-1:0]  cfg_arrive;
   logic [SPEED_W-1:0]  cfg_min_speed;
   logic [SPEED_W-1:0]  cfg_max_speed;

   // Predictor copy of the depth history. It is a ring that holds up to
   // HISTORY_DEPTH samples. The plain sum and the weighted sum are kept up to
   // date with every sample, so the average is one division.
   int depth_ring [HISTORY_DEPTH];
   int ring_count = 0;
   int ring_oldest = 0;
   int ring_sum = 0;
   int ring_weighted_sum = 0;
   logic track_state = 1'b0;

   weighted_depth_approach_controller i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_depth_mm         (req_depth_mm),
      .req_target_seen      (req_target_seen),
      .req_target_x         (req_target_x),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_weighted_average (rsp_weighted_average),
      .rsp_forward_speed    (rsp_forward_speed),
      .rsp_turn_rate        (rsp_turn_rate),
      .rsp_arrived          (rsp_arrived),
      .rsp_tracking_on      (rsp_tracking_on),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Floor of the linearly weighted average. The oldest sample has weight 1
   // and the newest has weight n. The average is 0 while the history is empty.
   function automatic int held_average();
      int weight_total;
      int quotient;
      if (ring_count == 0) begin
         return 0;
      end
      weight_total = ring_count * (ring_count + 1) / 2;
      quotient = ring_weighted_sum / weight_total;
      return (quotient > DEPTH_MAX) ? DEPTH_MAX : quotient;
   endfunction

   // Advances the predictor by one accepted beat and returns the reply that
   // the block must give for that beat.
   function automatic approach_reply_type predict_reply(input logic [KIND_W-1:0] kind,
                                                        input logic [DEPTH_W-1:0] depth,
                                                        input logic seen,
                                                        input logic [X_W-1:0] x);
      approach_reply_type reply;
      int d;
      int slot;
      int err;
      int turn;
      int avg;
      int speed;
      logic arrived;
      turn = 0;
      speed = 0;
      arrived = 1'b0;
      case (kind)
         wdac_pkg::KIND_DEPTH: begin
            d = int'(depth);
            if (d < DEPTH_MIN) d = DEPTH_MIN;
            if (d > DEPTH_MAX) d = DEPTH_MAX;
            if (ring_count < HISTORY_DEPTH) begin
               slot = (ring_oldest + ring_count) % HISTORY_DEPTH;
               ring_count++;
               depth_ring[slot] = d;
               ring_sum += d;
               ring_weighted_sum += ring_count * d;
            end else begin
               // When the ring is full, every weight that remains falls by one.
               // This is the same as subtracting the plain sum.
               ring_weighted_sum = ring_weighted_sum - ring_sum + HISTORY_DEPTH * d;
               ring_sum = ring_sum - depth_ring[ring_oldest] + d;
               depth_ring[ring_oldest] = d;
               ring_oldest = (ring_oldest + 1) % HISTORY_DEPTH;
            end
            if (track_state && held_average() < int'(cfg_arrive)) begin
               track_state = 1'b0;
               arrived = 1'b1;
            end
         end
         wdac_pkg::KIND_START: begin
            track_state = 1'b1;
         end
         wdac_pkg::KIND_TICK: begin
            if (track_state) begin
               if (!seen) begin
                  turn = int'(cfg_search);
               end else begin
                  err = int'(x) - int'(cfg_center);
                  turn = -int'(cfg_gain) * err;
                  if (turn > TURN_LIMIT) turn = TURN_LIMIT;
                  if (turn < -TURN_LIMIT) turn = -TURN_LIMIT;
                  avg = held_average();
                  if (avg > int'(cfg_stop)) begin
                     speed = avg / 2;
                     if (speed < int'(cfg_min_speed)) speed = int'(cfg_min_speed);
                     if (speed > int'(cfg_max_speed)) speed = int'(cfg_max_speed);
                     if (speed > SPEED_LIMIT) speed = SPEED_LIMIT;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      avg = held_average();
      reply.average = avg[DEPTH_W-1:0];
      reply.speed = speed[SPEED_W-1:0];
      reply.turn = turn[TURN_W-1:0];
      reply.arrived = arrived;
      reply.tracking = track_state;
      return reply;
   endfunction

   // Reply checker and reply stall driver. The checker samples at the rising
   // edge, so it sees the stall value that was in force at that edge. The new
   // stall value takes effect only after the edge.
   always @(posedge clock) begin : check_replies
      approach_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected reply: avg=%0d speed=%0d turn=%0d",
                        rsp_weighted_average, rsp_forward_speed, rsp_turn_rate);
               $display("   arrived=%0b tracking=%0b", rsp_arrived, rsp_tracking_on);
            end
         end else begin
            want = pending_replies[0];
            pending_replies.delete(0);
            if (rsp_weighted_average !== want.average || rsp_forward_speed !== want.speed ||
                rsp_turn_rate !== want.turn || rsp_arrived !== want.arrived ||
                rsp_tracking_on !== want.tracking) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("reply mismatch at %0t: expected avg=%0d speed=%0d turn=%0d",
                           $time, want.average, want.speed, want.turn);
                  $display("   arrived=%0b tracking=%0b; got avg=%0d speed=%0d turn=%0d",
                           want.arrived, want.tracking, rsp_weighted_average,
                           rsp_forward_speed, rsp_turn_rate);
                  $display("   arrived=%0b tracking=%0b", rsp_arrived, rsp_tracking_on);
               end
            end
         end
      end
      rsp_stall <= receiver_stalls && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Offers one request beat and returns at the edge where the block accepts
   // it. This task is entered at a rising edge. It leaves valid high, so the
   // next beat can follow without a gap.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [DEPTH_W-1:0] depth,
                            input logic seen, input logic [X_W-1:0] x);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_depth_mm <= depth;
      req_target_seen <= seen;
      req_target_x <= x;
      do @(posedge clock); while (req_stall);
      pending_replies.insert(pending_replies.size(), predict_reply(kind, depth, seen, x));
      if (kind != KIND_UNUSED) begin
         beats_sent++;
      end
   endtask

   // Waits until every reply has arrived and the block has settled. Then it
   // writes all seven registers, one at each edge, and updates the
   // predictor's copy of each one.
   task automatic apply_settings(input logic [CSR_DAT_W-1:0] center,
                                 input logic [CSR_DAT_W-1:0] gain,
                                 input logic [CSR_DAT_W-1:0] search,
                                 input logic [CSR_DAT_W-1:0] stop,
                                 input logic [CSR_DAT_W-1:0] arrive,
                                 input logic [CSR_DAT_W-1:0] min_speed,
                                 input logic [CSR_DAT_W-1:0] max_speed);
      logic [CSR_DAT_W-1:0] values [7];
      logic [CSR_IDX_W-1:0] idx;
      values = '{center, gain, search, stop, arrive, min_speed, max_speed};
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         idx = i[CSR_IDX_W-1:0];
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= values[i];
         @(posedge clock);
         case (idx)
            wdac_pkg::CSR_IMAGE_CENTER:    cfg_center = values[i][X_W-1:0];
            wdac_pkg::CSR_STEER_GAIN:      cfg_gain = values[i][GAIN_W-1:0];
            wdac_pkg::CSR_SEARCH_RATE:     cfg_search = values[i][SEARCH_W-1:0];
            wdac_pkg::CSR_STOP_DISTANCE:   cfg_stop = values[i][DEPTH_W-1:0];
            wdac_pkg::CSR_ARRIVE_DISTANCE: cfg_arrive = values[i][DEPTH_W-1:0];
            wdac_pkg::CSR_MIN_SPEED:       cfg_min_speed = values[i][SPEED_W-1:0];
            wdac_pkg::CSR_MAX_SPEED:       cfg_max_speed = values[i][SPEED_W-1:0];
            default: begin
            end
         endcase
      end
      csr_write_en <= 1'b0;
   endtask

   // Random traffic until the given number of meaningful beats is accepted.
   // Approach runs dominate. Each run is a start, then depths that fall from
   // somewhere in range toward the floor, with ticks mixed in. These runs
   // pass through the speed band and usually end in arrival.
   task automatic run_traffic(input int beats);
      int goal;
      int pick;
      int far;
      int step;
      int run_length;
      int d;
      goal = beats_sent + beats;
      while (beats_sent < goal) begin
         pick = int'($urandom_range(99));
         if (pick < 65) begin
            send_beat(wdac_pkg::KIND_START, DEPTH_W'($urandom_range(16383)),
                      1'($urandom_range(1)), X_W'($urandom_range(1023)));
            far = int'($urandom_range(DEPTH_MIN + 600, DEPTH_MAX));
            step = int'($urandom_range(20, 600));
            run_length = int'($urandom_range(4, 40));
            for (int i = 0; i < run_length; i++) begin
               d = far - i * step + int'($urandom_range(100)) - 50;
               if (d < 0) d = int'($urandom_range(200));
               send_beat(wdac_pkg::KIND_DEPTH, d[DEPTH_W-1:0], 1'($urandom_range(1)),
                         X_W'($urandom_range(1023)));
               if ($urandom_range(1)) begin
                  send_beat(wdac_pkg::KIND_TICK, DEPTH_W'($urandom_range(16383)),
                            $urandom_range(99) < 85, X_W'($urandom_range(1023)));
               end
            end
         end else if (pick < 88) begin
            send_beat(KIND_W'($urandom_range(3)), DEPTH_W'($urandom_range(16383)),
                      1'($urandom_range(1)), X_W'($urandom_range(1023)));
         end else begin
            // A broken sequence: depths and ticks with no fresh start. These
            // beats often arrive after an arrival has already cleared tracking.
            repeat ($urandom_range(1, 6)) begin
               send_beat($urandom_range(1) ? wdac_pkg::KIND_TICK : wdac_pkg::KIND_DEPTH,
                         DEPTH_W'($urandom_range(16383)), 1'($urandom_range(1)),
                         X_W'($urandom_range(1023)));
            end
         end
      end
   endtask

   // Before any start, every beat must leave tracking off. Depth samples are
   // still clamped, stored and averaged.
   task automatic test_untracked_beats();
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b0, 10'd1023);
      send_beat(KIND_UNUSED, 14'h3FFF, 1'b1, 10'h3FF);
      send_beat(wdac_pkg::KIND_DEPTH, 14'd0, 1'b1, 10'd0);
      send_beat(wdac_pkg::KIND_DEPTH, 14'h3FFF, 1'b0, 10'd0);
      send_beat(wdac_pkg::KIND_DEPTH, DEPTH_W'(DEPTH_MIN - 1), 1'b0, 10'd512);
      send_beat(wdac_pkg::KIND_DEPTH, DEPTH_W'(DEPTH_MAX + 1), 1'b1, 10'd512);
      send_beat(wdac_pkg::KIND_DEPTH, DEPTH_W'(DEPTH_MIN), 1'b0, 10'd0);
      send_beat(wdac_pkg::KIND_DEPTH, DEPTH_W'(DEPTH_MAX), 1'b0, 10'd0);
      send_beat(wdac_pkg::KIND_TICK, 14'd5000, 1'b1, 10'd320);
   endtask

   // Start, a repeated start, ticks at both ends of the image and at the
   // center, an unseen tick, the unused kind while tracking, and then near
   // samples that pull the average down, and a last seen tick.
   task automatic test_tracking_path();
      send_beat(wdac_pkg::KIND_START, 14'd0, 1'b0, 10'd0);
      send_beat(wdac_pkg::KIND_START, 14'h3FFF, 1'b1, 10'h3FF);
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b1, 10'd0);
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b1, 10'd1023);
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b1, 10'd320);
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b0, 10'd700);
      send_beat(KIND_UNUSED, 14'd100, 1'b0, 10'd0);
      repeat (6) send_beat(wdac_pkg::KIND_DEPTH, DEPTH_W'(DEPTH_MIN), 1'b0, 10'd0);
      send_beat(wdac_pkg::KIND_TICK, 14'd0, 1'b1, 10'd100);
   endtask

   task automatic test_default_traffic();
      run_traffic(400);
   endtask

   // Register extremes. With the first two settings, gain, search rate and
   // speed limits sit at the top of their widths. With gain 127 the turn
   // saturates in both directions, and with both speed limits at 1023 the
   // speed saturates at the output limit. With the last setting, every register
   // sits at zero or at full depth, so every tracked depth sample arrives at once.
   task automatic test_extreme_settings();
      apply_settings(14'd1023, 14'd127, 14'd4095, 14'd0, 14'd0, 14'd1023, 14'd1023);
      run_traffic(150);
      apply_settings(14'd0, 14'd127, 14'd4095, 14'd10000, 14'd10000, 14'd1023, 14'd1023);
      run_traffic(120);
      apply_settings(14'd0, 14'd0, 14'd0, 14'h3FFF, 14'h3FFF, 14'd0, 14'd0);
      run_traffic(120);
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         apply_settings(CSR_DAT_W'($urandom_range(1023)), CSR_DAT_W'($urandom_range(100)),
                        CSR_DAT_W'($urandom_range(4000)), CSR_DAT_W'($urandom_range(10000)),
                        CSR_DAT_W'($urandom_range(1500)), CSR_DAT_W'($urandom_range(1000)),
                        CSR_DAT_W'($urandom_range(1000)));
         run_traffic(190);
      end
   endtask

   // Back-to-back beats on both sides with no idle cycles and no stalls.
   task automatic test_full_rate();
      apply_settings(14'd320, 14'd10, 14'd500, 14'd200, 14'd400, 14'd50, 14'd300);
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      run_traffic(200);
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      req_valid = 1'b0;
      req_kind = wdac_pkg::KIND_DEPTH;
      req_depth_mm = '0;
      req_target_seen = 1'b0;
      req_target_x = '0;
      csr_write_en = 1'b0;
      csr_index = wdac_pkg::CSR_IMAGE_CENTER;
      csr_wdata = '0;
      cfg_center = wdac_pkg::IMAGE_CENTER_RST;
      cfg_gain = wdac_pkg::STEER_GAIN_RST;
      cfg_search = wdac_pkg::SEARCH_RATE_RST;
      cfg_stop = wdac_pkg::STOP_DISTANCE_RST;
      cfg_arrive = wdac_pkg::ARRIVE_DISTANCE_RST;
      cfg_min_speed = wdac_pkg::MIN_SPEED_RST;
      cfg_max_speed = wdac_pkg::MAX_SPEED_RST;
      foreach (depth_ring[i]) depth_ring[i] = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_untracked_beats();
      test_tracking_path();
      test_default_traffic();
      test_extreme_settings();
      test_random_settings();
      test_full_rate();

      // Let the last replies drain. A reply that never comes counts as a
      // failure.
      req_valid <= 1'b0;
      for (int i = 0; i < 200000 && pending_replies.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $display("%0d expected replies never arrived", pending_replies.size());
         mismatch_count += pending_replies.size();
      end
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog. It allows far more time than the slowest correct run needs.
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
